// File: design/mchw_pkg.sv
// Shared types, constants and helpers of the heartbeat watchdog.
// Used by mchw_front, mchw_fifo, mchw_back and the top level; no dependencies.
package mchw_pkg;

    localparam int MAX_CLIENTS_DEF = 8;
    localparam int FIFO_DEPTH      = 2;

    localparam logic [31:0] LIMIT_TOP       = 32'h7FFF_FFFF;
    localparam logic [31:0] MIN_SILENCE_RST = 32'd100;

    localparam logic [2:0] CMD_REGISTER   = 3'd0;
    localparam logic [2:0] CMD_UNREGISTER = 3'd1;
    localparam logic [2:0] CMD_HEARTBEAT  = 3'd2;
    localparam logic [2:0] CMD_CHECK      = 3'd3;
    localparam logic [2:0] CMD_SNAPSHOT   = 3'd4;

    typedef enum logic [2:0] {
        OP_REGISTER,
        OP_UNREGISTER,
        OP_HEARTBEAT,
        OP_CHECK,
        OP_SNAPSHOT,
        OP_INVALID
    } op_t;

    // Classified command word passed from front to back
    typedef struct packed {
        op_t         op;
        logic        pre_ok;
        logic [31:0] now_ms;
        logic [31:0] client_key;
        logic [31:0] limit_req;
        logic [7:0]  client_id;
    } cmd_word_t;

    typedef struct packed {
        logic        ok;
        logic [7:0]  slot_index;
        logic        slot_registered;
        logic [31:0] slot_key;
        logic [31:0] slot_limit_ms;
        logic [31:0] quiet_ms;
        logic        overdue;
        logic        expired;
        logic [31:0] feed_count;
        logic [6:0]  registered_count;
        logic        last;
    } result_t;

    function automatic result_t single_result(logic ok, logic [7:0] slot,
                                              logic [31:0] feed);
        result_t r;
        r            = '0;
        r.ok         = ok;
        r.slot_index = slot;
        r.feed_count = feed;
        r.last       = 1'b1;
        return r;
    endfunction

endpackage

// File: design/mchw_front.sv
// Front end of the heartbeat watchdog: holds the check period register and
// classifies each incoming command word. Depends on mchw_pkg.
module mchw_front #(
    parameter int MAX_CLIENTS = mchw_pkg::MAX_CLIENTS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [2:0]          cmd,
    input  logic [31:0]         now_ms,
    input  logic [31:0]         client_key,
    input  logic [31:0]         limit_req,
    input  logic [7:0]          client_id,
    input  logic                cfg_wr_en,
    input  logic [31:0]         cfg_wr_data,
    output logic                push_valid,
    input  logic                push_ready,
    output mchw_pkg::cmd_word_t push_word
);

    logic [31:0] min_silence_reg;
    logic [31:0] min_silence_next;
    logic        id_in_range;
    logic        limit_ok;

    assign min_silence_next = cfg_wr_en ? cfg_wr_data : min_silence_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_silence_reg <= mchw_pkg::MIN_SILENCE_RST;
        end
        else
        begin
            min_silence_reg <= min_silence_next;
        end
    end

    assign in_ready   = push_ready;
    assign push_valid = in_valid;

    assign id_in_range = client_id < 8'(MAX_CLIENTS);
    assign limit_ok    = (client_key != 32'd0) && (limit_req >= min_silence_reg)
                         && (limit_req <= mchw_pkg::LIMIT_TOP);

    always_comb
    begin
        push_word.now_ms     = now_ms;
        push_word.client_key = client_key;
        push_word.limit_req  = limit_req;
        push_word.client_id  = client_id;
        unique case (cmd)
            mchw_pkg::CMD_REGISTER:
            begin
                push_word.op     = mchw_pkg::OP_REGISTER;
                push_word.pre_ok = limit_ok;
            end
            mchw_pkg::CMD_UNREGISTER:
            begin
                push_word.op     = mchw_pkg::OP_UNREGISTER;
                push_word.pre_ok = id_in_range;
            end
            mchw_pkg::CMD_HEARTBEAT:
            begin
                push_word.op     = mchw_pkg::OP_HEARTBEAT;
                push_word.pre_ok = id_in_range;
            end
            mchw_pkg::CMD_CHECK:
            begin
                push_word.op     = mchw_pkg::OP_CHECK;
                push_word.pre_ok = 1'b1;
            end
            mchw_pkg::CMD_SNAPSHOT:
            begin
                push_word.op     = mchw_pkg::OP_SNAPSHOT;
                push_word.pre_ok = 1'b1;
            end
            default:
            begin
                push_word.op     = mchw_pkg::OP_INVALID;
                push_word.pre_ok = 1'b0;
            end
        endcase
    end

endmodule

// File: design/mchw_fifo.sv
// Short command queue between the front and back of the heartbeat watchdog.
// Depends on mchw_pkg for the command word type.
module mchw_fifo #(
    parameter int DEPTH = mchw_pkg::FIFO_DEPTH
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push_valid,
    output logic                push_ready,
    input  mchw_pkg::cmd_word_t push_word,
    output logic                pop_valid,
    input  logic                pop_ready,
    output mchw_pkg::cmd_word_t pop_word
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    mchw_pkg::cmd_word_t entry_reg [DEPTH];
    logic [PTR_W-1:0]    wr_ptr_reg;
    logic [PTR_W-1:0]    wr_ptr_next;
    logic [PTR_W-1:0]    rd_ptr_reg;
    logic [PTR_W-1:0]    rd_ptr_next;
    logic [CNT_W-1:0]    count_reg;
    logic [CNT_W-1:0]    count_next;
    logic                do_push;
    logic                do_pop;

    assign push_ready = count_reg != CNT_W'(DEPTH);
    assign pop_valid  = count_reg != '0;
    assign pop_word   = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_word;
        end
    end

endmodule

// File: design/mchw_back.sv
// Back end of the heartbeat watchdog: slot table, slot walk sequencer,
// feed counter, halt flag and the output register. Depends on mchw_pkg.
module mchw_back #(
    parameter int MAX_CLIENTS = mchw_pkg::MAX_CLIENTS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_valid,
    output logic                q_pop,
    input  mchw_pkg::cmd_word_t q_word,
    output logic                out_valid,
    input  logic                out_ready,
    output mchw_pkg::result_t   out_word
);

    localparam int SLOT_W = (MAX_CLIENTS > 1) ? $clog2(MAX_CLIENTS) : 1;
    localparam logic [SLOT_W-1:0] LAST_IDX = SLOT_W'(MAX_CLIENTS - 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_EVAL
    } state_t;

    state_t                  state_reg;
    state_t                  state_next;
    mchw_pkg::cmd_word_t     cur_reg;
    mchw_pkg::cmd_word_t     cur_next;
    logic [SLOT_W-1:0]       scan_reg;
    logic [SLOT_W-1:0]       scan_next;
    logic                    free_found_reg;
    logic                    free_found_next;
    logic [SLOT_W-1:0]       free_idx_reg;
    logic [SLOT_W-1:0]       free_idx_next;
    logic [MAX_CLIENTS-1:0]  valid_reg;
    logic [MAX_CLIENTS-1:0]  valid_next;
    logic [6:0]              count_reg;
    logic [6:0]              count_next;
    logic [31:0]             feed_reg;
    logic [31:0]             feed_next;
    logic                    halted_reg;
    logic                    halted_next;
    logic                    out_valid_reg;
    logic                    out_valid_next;
    mchw_pkg::result_t       out_reg;
    mchw_pkg::result_t       out_next;

    // slot table memories, one read port at the walk index
    logic [31:0]             key_mem  [MAX_CLIENTS];
    logic [31:0]             lim_mem  [MAX_CLIENTS];
    logic [31:0]             seen_mem [MAX_CLIENTS];
    logic [31:0]             rd_key_reg;
    logic [31:0]             rd_lim_reg;
    logic [31:0]             rd_seen_reg;
    logic                    key_we;
    logic                    seen_we;
    logic [SLOT_W-1:0]       wr_addr;
    logic [31:0]             wr_seen;

    logic                    can_emit;
    logic [SLOT_W-1:0]       q_id;
    logic                    slot_v;
    logic                    is_last;
    logic [31:0]             sil;
    logic                    over;
    logic                    dup;
    logic                    have_free;
    logic [SLOT_W-1:0]       reg_idx;
    mchw_pkg::result_t       snap_rec;

    assign can_emit  = !out_valid_reg || out_ready;
    assign q_id      = q_word.client_id[SLOT_W-1:0];
    assign slot_v    = valid_reg[scan_reg];
    assign is_last   = scan_reg == LAST_IDX;
    assign sil       = cur_reg.now_ms - rd_seen_reg;
    assign over      = sil > rd_lim_reg;
    assign dup       = slot_v && (rd_key_reg == cur_reg.client_key);
    assign have_free = free_found_reg || !slot_v;
    assign reg_idx   = free_found_reg ? free_idx_reg : scan_reg;

    always_comb
    begin
        snap_rec                  = '0;
        snap_rec.ok               = 1'b1;
        snap_rec.slot_index       = 8'(scan_reg);
        snap_rec.registered_count = count_reg;
        snap_rec.feed_count       = feed_reg;
        snap_rec.last             = is_last;
        if (slot_v)
        begin
            snap_rec.slot_registered = 1'b1;
            snap_rec.slot_key        = rd_key_reg;
            snap_rec.slot_limit_ms   = rd_lim_reg;
            snap_rec.quiet_ms        = sil;
            snap_rec.overdue         = over;
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        cur_next        = cur_reg;
        scan_next       = scan_reg;
        free_found_next = free_found_reg;
        free_idx_next   = free_idx_reg;
        valid_next      = valid_reg;
        count_next      = count_reg;
        feed_next       = feed_reg;
        halted_next     = halted_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_next        = out_reg;
        q_pop           = 1'b0;
        key_we          = 1'b0;
        seen_we         = 1'b0;
        wr_addr         = scan_reg;
        wr_seen         = cur_reg.now_ms;

        unique case (state_reg)
            S_IDLE:
            begin
                if (q_valid && can_emit)
                begin
                    q_pop           = 1'b1;
                    cur_next        = q_word;
                    scan_next       = '0;
                    free_found_next = 1'b0;
                    free_idx_next   = '0;
                    if (halted_reg)
                    begin
                        out_valid_next = 1'b1;
                        out_next       = mchw_pkg::single_result(1'b0, 8'd0, feed_reg);
                    end
                    else
                    begin
                        unique case (q_word.op) inside
                            mchw_pkg::OP_UNREGISTER:
                            begin
                                out_valid_next = 1'b1;
                                if (q_word.pre_ok && valid_reg[q_id])
                                begin
                                    valid_next[q_id] = 1'b0;
                                    count_next       = count_reg - 7'd1;
                                    out_next = mchw_pkg::single_result(1'b1, 8'd0, feed_reg);
                                end
                                else
                                begin
                                    out_next = mchw_pkg::single_result(1'b0, 8'd0, feed_reg);
                                end
                            end
                            mchw_pkg::OP_HEARTBEAT:
                            begin
                                out_valid_next = 1'b1;
                                if (q_word.pre_ok && valid_reg[q_id])
                                begin
                                    seen_we  = 1'b1;
                                    wr_addr  = q_id;
                                    wr_seen  = q_word.now_ms;
                                    out_next = mchw_pkg::single_result(1'b1, 8'd0, feed_reg);
                                end
                                else
                                begin
                                    out_next = mchw_pkg::single_result(1'b0, 8'd0, feed_reg);
                                end
                            end
                            mchw_pkg::OP_REGISTER:
                            begin
                                if (q_word.pre_ok)
                                begin
                                    state_next = S_READ;
                                end
                                else
                                begin
                                    out_valid_next = 1'b1;
                                    out_next = mchw_pkg::single_result(1'b0, 8'd0, feed_reg);
                                end
                            end
                            mchw_pkg::OP_CHECK, mchw_pkg::OP_SNAPSHOT:
                            begin
                                state_next = S_READ;
                            end
                            default:
                            begin
                                out_valid_next = 1'b1;
                                out_next = mchw_pkg::single_result(1'b0, 8'd0, feed_reg);
                            end
                        endcase
                    end
                end
            end
            S_READ:
            begin
                // wait for the registered slot read
                state_next = S_EVAL;
            end
            S_EVAL:
            begin
                unique case (cur_reg.op) inside
                    mchw_pkg::OP_REGISTER:
                    begin
                        if (dup)
                        begin
                            if (can_emit)
                            begin
                                out_valid_next = 1'b1;
                                out_next   = mchw_pkg::single_result(1'b0, 8'd0, feed_reg);
                                state_next = S_IDLE;
                            end
                        end
                        else if (is_last)
                        begin
                            if (can_emit)
                            begin
                                out_valid_next = 1'b1;
                                state_next     = S_IDLE;
                                if (have_free)
                                begin
                                    key_we              = 1'b1;
                                    seen_we             = 1'b1;
                                    wr_addr             = reg_idx;
                                    valid_next[reg_idx] = 1'b1;
                                    count_next          = count_reg + 7'd1;
                                    out_next = mchw_pkg::single_result(1'b1, 8'(reg_idx),
                                                                       feed_reg);
                                end
                                else
                                begin
                                    out_next = mchw_pkg::single_result(1'b0, 8'd0, feed_reg);
                                end
                            end
                        end
                        else
                        begin
                            // remember the lowest empty slot, advance
                            if (!slot_v && !free_found_reg)
                            begin
                                free_found_next = 1'b1;
                                free_idx_next   = scan_reg;
                            end
                            scan_next  = scan_reg + 1'b1;
                            state_next = S_READ;
                        end
                    end
                    mchw_pkg::OP_CHECK:
                    begin
                        if (slot_v && over)
                        begin
                            if (can_emit)
                            begin
                                out_valid_next = 1'b1;
                                out_next = mchw_pkg::single_result(1'b0, 8'(scan_reg), feed_reg);
                                out_next.expired = 1'b1;
                                halted_next      = 1'b1;
                                state_next       = S_IDLE;
                            end
                        end
                        else if (is_last)
                        begin
                            if (can_emit)
                            begin
                                feed_next      = feed_reg + 32'd1;
                                out_valid_next = 1'b1;
                                out_next = mchw_pkg::single_result(1'b1, 8'd0,
                                                                   feed_reg + 32'd1);
                                state_next     = S_IDLE;
                            end
                        end
                        else
                        begin
                            scan_next  = scan_reg + 1'b1;
                            state_next = S_READ;
                        end
                    end
                    default:
                    begin
                        // snapshot: one word per slot, hold while the output is full
                        if (can_emit)
                        begin
                            out_valid_next = 1'b1;
                            out_next       = snap_rec;
                            if (is_last)
                            begin
                                state_next = S_IDLE;
                            end
                            else
                            begin
                                scan_next  = scan_reg + 1'b1;
                                state_next = S_READ;
                            end
                        end
                    end
                endcase
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            cur_reg        <= '0;
            scan_reg       <= '0;
            free_found_reg <= 1'b0;
            free_idx_reg   <= '0;
            valid_reg      <= '0;
            count_reg      <= '0;
            feed_reg       <= '0;
            halted_reg     <= 1'b0;
            out_valid_reg  <= 1'b0;
            out_reg        <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            cur_reg        <= cur_next;
            scan_reg       <= scan_next;
            free_found_reg <= free_found_next;
            free_idx_reg   <= free_idx_next;
            valid_reg      <= valid_next;
            count_reg      <= count_next;
            feed_reg       <= feed_next;
            halted_reg     <= halted_next;
            out_valid_reg  <= out_valid_next;
            out_reg        <= out_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (key_we)
        begin
            key_mem[wr_addr] <= cur_reg.client_key;
            lim_mem[wr_addr] <= cur_reg.limit_req;
        end
        if (seen_we)
        begin
            seen_mem[wr_addr] <= wr_seen;
        end
        rd_key_reg  <= key_mem[scan_reg];
        rd_lim_reg  <= lim_mem[scan_reg];
        rd_seen_reg <= seen_mem[scan_reg];
    end

    assign out_valid = out_valid_reg;
    assign out_word  = out_reg;

    a_count_matches: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(valid_reg) == int'(count_reg))
        else $error("registered count disagrees with valid bits");

    a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= 7'(MAX_CLIENTS))
        else $error("registered count above table size");

    a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        halted_reg |=> halted_reg)
        else $error("halt flag cleared");

    a_halt_no_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && halted_reg) |-> !out_reg.ok)
        else $error("accepted result while halted");

    a_expired_halts: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.expired) |-> (halted_reg && !out_reg.ok))
        else $error("expiry reported without halt");

endmodule

// File: design/multi_client_heartbeat_watchdog_unit.sv
// Heartbeat watchdog for several software clients: top level.
// Instantiates mchw_front, mchw_fifo and mchw_back; depends on mchw_pkg.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one command word: register,
//   unregister, heartbeat, check pass or snapshot, with the current time.
//   Output channel (out_valid/out_ready) carries result words; last marks the
//   final word of a command. A snapshot gives MAX_CLIENTS words, every other
//   command exactly one; while halted every command gives one rejected word.
//   cfg_wr_en/cfg_wr_data write the check period (minimum accepted limit).
// Command flow:
//   Unregister, heartbeat, rejected register and unknown commands: result
//   registered when the command leaves the queue; one command per cycle
//   while the receiver takes each word. Register, check and snapshot walk the
//   slot table through the single read port of the slot memories, each slot
//   in a read state then an evaluate state. A two-word queue keeps accepting
//   while the walk runs.
// Reset: all slots empty, feed count zero, not halted, check period 100 ms.
// Receiver stall: the output register holds its word; the walk pauses on the
// slot that must be reported and resumes when the word is taken.
module multi_client_heartbeat_watchdog_unit #(
    parameter int MAX_CLIENTS = mchw_pkg::MAX_CLIENTS_DEF,
    parameter int QUEUE_DEPTH = mchw_pkg::FIFO_DEPTH
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [2:0]  cmd,
    input  logic [31:0] now_ms,
    input  logic [31:0] client_key,
    input  logic [31:0] limit_req,
    input  logic [7:0]  client_id,
    input  logic        cfg_wr_en,
    input  logic [31:0] cfg_wr_data,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        ok,
    output logic [7:0]  slot_index,
    output logic        slot_registered,
    output logic [31:0] slot_key,
    output logic [31:0] slot_limit_ms,
    output logic [31:0] quiet_ms,
    output logic        overdue,
    output logic        expired,
    output logic [31:0] feed_count,
    output logic [6:0]  registered_count,
    output logic        last
);

    logic                push_valid;
    logic                push_ready;
    mchw_pkg::cmd_word_t push_word;
    logic                q_valid;
    logic                q_pop;
    mchw_pkg::cmd_word_t q_word;
    mchw_pkg::result_t   res_word;

    mchw_front #(
        .MAX_CLIENTS (MAX_CLIENTS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .cmd         (cmd),
        .now_ms      (now_ms),
        .client_key  (client_key),
        .limit_req   (limit_req),
        .client_id   (client_id),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .push_valid  (push_valid),
        .push_ready  (push_ready),
        .push_word   (push_word)
    );

    mchw_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_word  (push_word),
        .pop_valid  (q_valid),
        .pop_ready  (q_pop),
        .pop_word   (q_word)
    );

    mchw_back #(
        .MAX_CLIENTS (MAX_CLIENTS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_pop     (q_pop),
        .q_word    (q_word),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_word  (res_word)
    );

    assign ok               = res_word.ok;
    assign slot_index       = res_word.slot_index;
    assign slot_registered  = res_word.slot_registered;
    assign slot_key         = res_word.slot_key;
    assign slot_limit_ms    = res_word.slot_limit_ms;
    assign quiet_ms         = res_word.quiet_ms;
    assign overdue          = res_word.overdue;
    assign expired          = res_word.expired;
    assign feed_count       = res_word.feed_count;
    assign registered_count = res_word.registered_count;
    assign last             = res_word.last;

endmodule
